@@ design/mvo_pkg.sv @@
// Shared types and constants for the multi-voice oscillator mixer.
// Holds the request/result payloads, the voice chain link and the op codes.
// No dependencies.
package mvo_pkg;

	localparam int PHASE_BITS = 24;
	localparam int RATE_HZ    = 22050;
	localparam int NOTE_MAX   = 72;
	localparam int WAVE_W     = 17;
	localparam int PROD_W     = 24;

	localparam logic [7:0]  FX_VOLUME   = 8'h0C;
	localparam logic [14:0] AMP_RESET   = 15'd16000;
	localparam logic [7:0]  VOL_DEFAULT = 8'd100;

	typedef enum logic [1:0] {
		FUNC_TICK     = 2'd0,
		FUNC_NOTE_ON  = 2'd1,
		FUNC_NOTE_OFF = 2'd2,
		FUNC_UNUSED   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_TICK,
		OP_ON,
		OP_OFF
	} op_t;

	typedef enum logic [1:0] {
		SHAPE_SINE,
		SHAPE_SQUARE,
		SHAPE_TRIANGLE,
		SHAPE_SAW
	} wave_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  channel;
		logic [6:0]  note;
		logic [7:0]  instrument;
		logic [15:0] effect;
	} item_t;

	typedef struct packed {
		logic signed [15:0] sample;
	} result_t;

	typedef struct packed {
		logic                  valid;
		op_t                   op;
		logic [2:0]            channel;
		logic [PHASE_BITS-1:0] inc;
		wave_t                 wave;
		logic [7:0]            volume;
	} link_t;

endpackage

@@ design/mvo_stream_if.sv @@
// Valid/ready stream channel used for the request and result ports.
// The payload type is set per instance; no other dependencies.
interface mvo_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/multi_voice_oscillator_mixer.sv @@
// Multi-voice tone generator with mixed sample output.
// Top level: request decode, amplitude register, voice chain and output stage.
// Depends on mvo_pkg, mvo_stream_if, mvo_cell and mvo_clip.
//
// Usage:
//   item   - request channel (func, channel, note, instrument, effect), taken
//            when valid and ready are both high.
//   result - one signed sample for every tick request; note on, note off and
//            unused codes give none.
//   cfg_we/cfg_wdata - amplitude register, written while the block is idle.
// A request walks the chain of VOICE_COUNT voice cells, each cell registering it,
// then the sum is scaled into a register and clipped into the output register.
// The block does not take a new request before it is done with the last one: a
// counter holds the input while the request passes the voice chain and the
// scaling stage.
// Reset: all voices silent, phase and increment zero, sine, volume 100,
// amplitude 16000; ready from the first cycle after reset.
// A stalled receiver holds the sample in the output register; one further
// tick is accepted and waits in the scaling stage, then the input stalls.
module multi_voice_oscillator_mixer
	import mvo_pkg::*;
#(
	parameter int VOICE_COUNT = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [14:0]  cfg_wdata,
	mvo_stream_if.sink   item,
	mvo_stream_if.source result
);

	localparam int SUM_W = PROD_W + $clog2(VOICE_COUNT);
	localparam int CNT_W = $clog2(VOICE_COUNT + 3);
	localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VOICE_COUNT + 2);
	localparam logic [63:0] INC_DEN = 64'(RATE_HZ) << 15;
	localparam logic [21:0] BASE_FREQ [12] = '{
		22'd1802240, 22'd1909407, 22'd2022946, 22'd2143237, 22'd2270680, 22'd2405702,
		22'd2548752, 22'd2700309, 22'd2860878, 22'd3030994, 22'd3211227, 22'd3402176
	};

	typedef logic [PHASE_BITS-1:0] inc_table_t [NOTE_MAX+1];

	function automatic inc_table_t build_inc_table();
		inc_table_t  tbl;
		logic [63:0] num;
		int          m;
		int          n;
		tbl[0] = '0;
		for (n = 1; n <= NOTE_MAX; n++) begin
			m      = n + 2;
			num    = 64'(BASE_FREQ[m % 12]) << (PHASE_BITS + m / 12);
			tbl[n] = PHASE_BITS'((num + INC_DEN / 2) / INC_DEN);
		end
		return tbl;
	endfunction

	localparam inc_table_t INC_TABLE = build_inc_table();

	logic [14:0]      amplitude_q;
	logic [CNT_W-1:0] cnt_q;

	item_t                   req;
	logic                    accept;
	logic                    note_ok;
	logic                    tail_busy;
	link_t                   link0;
	link_t                   links [VOICE_COUNT+1];
	logic signed [SUM_W-1:0] sums [VOICE_COUNT+1];

	assign req        = item.data;
	assign item.ready = (cnt_q == '0) && !tail_busy;
	assign accept     = item.valid && item.ready;
	assign note_ok    = (req.note >= 7'd1) && (req.note <= 7'(NOTE_MAX));

	always_comb begin
		link0.valid   = accept;
		link0.channel = req.channel;
		link0.inc     = note_ok ? INC_TABLE[req.note] : '0;
		unique case (req.func)
			FUNC_TICK:     link0.op = OP_TICK;
			FUNC_NOTE_ON:  link0.op = note_ok ? OP_ON : OP_NONE;
			FUNC_NOTE_OFF: link0.op = OP_OFF;
			default:       link0.op = OP_NONE;
		endcase
		case (req.instrument) inside
			8'd2, 8'd5: link0.wave = SHAPE_SQUARE;
			8'd3:       link0.wave = SHAPE_TRIANGLE;
			8'd4:       link0.wave = SHAPE_SAW;
			default:    link0.wave = SHAPE_SINE;
		endcase
		unique case (req.instrument)
			8'd1:    link0.volume = 8'd120;
			8'd2:    link0.volume = 8'd100;
			8'd3:    link0.volume = 8'd110;
			8'd4:    link0.volume = 8'd90;
			8'd5:    link0.volume = 8'd70;
			default: link0.volume = VOL_DEFAULT;
		endcase
		if (req.effect[15:8] == FX_VOLUME) begin
			link0.volume = req.effect[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amplitude_q <= AMP_RESET;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				amplitude_q <= cfg_wdata;
			end
			if (accept) begin
				cnt_q <= CNT_LOAD;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign links[0] = link0;
	assign sums[0]  = '0;

	for (genvar g = 0; g < VOICE_COUNT; g++) begin : g_voice
		mvo_cell #(
			.INDEX (g),
			.SUM_W (SUM_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.link_in  (links[g]),
			.sum_in   (sums[g]),
			.link_out (links[g+1]),
			.sum_out  (sums[g+1])
		);
	end

	mvo_clip #(
		.SUM_W (SUM_W)
	) u_clip (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (links[VOICE_COUNT].valid && (links[VOICE_COUNT].op == OP_TICK)),
		.sum       (sums[VOICE_COUNT]),
		.amplitude (amplitude_q),
		.busy      (tail_busy),
		.result    (result)
	);

endmodule

@@ design/mvo_cell.sv @@
// One voice of the oscillator chain: holds the voice state, applies requests
// passing along the chain and adds its weighted wave value to the running sum.
// Depends on mvo_pkg.
module mvo_cell
	import mvo_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int SUM_W = 27
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  link_t                   link_in,
	input  logic signed [SUM_W-1:0] sum_in,
	output link_t                   link_out,
	output logic signed [SUM_W-1:0] sum_out
);

	localparam logic [15:0] QUARTER_SINE [33] = '{
		16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,  16'd9512,
		16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846, 16'd18205, 16'd19520,
		16'd20788, 16'd22006, 16'd23170, 16'd24279, 16'd25329, 16'd26319, 16'd27245,
		16'd28105, 16'd28898, 16'd29621, 16'd30273, 16'd30852, 16'd31356, 16'd31785,
		16'd32138, 16'd32413, 16'd32609, 16'd32729, 16'd32768
	};

	logic                     active_q;
	logic [PHASE_BITS-1:0]    phase_q;
	logic [PHASE_BITS-1:0]    inc_q;
	wave_t                    wave_q;
	logic [7:0]               volume_q;
	logic signed [WAVE_W-1:0] wave_s1;
	logic signed [PROD_W-1:0] prod_s2;
	link_t                    link_q;
	logic signed [SUM_W-1:0]  sum_q;

	logic                     hit;
	logic [15:0]              p;
	logic [14:0]              r;
	logic [5:0]               idx;
	logic [5:0]               lo_idx;
	logic [5:0]               hi_idx;
	logic [15:0]              lo_v;
	logic [15:0]              hi_v;
	logic [24:0]              interp;
	logic [16:0]              mag;
	logic signed [18:0]       two_p;
	logic signed [18:0]       tri_v;
	logic signed [WAVE_W-1:0] wave_val;
	logic signed [WAVE_W+8:0] prod_full;

	assign hit = link_in.valid && (link_in.channel == 3'(INDEX));

	always_comb begin
		p      = phase_q[PHASE_BITS-1 -: 16];
		r      = p[14] ? (15'h4000 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
		idx    = r[14:9];
		lo_idx = {1'b0, idx[4:0]};
		hi_idx = lo_idx + 6'd1;
		lo_v   = QUARTER_SINE[lo_idx];
		hi_v   = QUARTER_SINE[hi_idx];
		interp = 25'(hi_v - lo_v) * 25'(r[8:0]);
		mag    = (idx[5]) ? 17'd32768 : ({1'b0, lo_v} + 17'(interp >> 9));
		two_p  = $signed({2'b00, p, 1'b0});
		if (p < 16'd16384) begin
			tri_v = two_p;
		end else if (p < 16'd49152) begin
			tri_v = 19'sd65536 - two_p;
		end else begin
			tri_v = two_p - 19'sd131072;
		end
		unique case (wave_q)
			SHAPE_SQUARE:   wave_val = p[15] ? -17'sd32768 : 17'sd32768;
			SHAPE_TRIANGLE: wave_val = WAVE_W'(tri_v);
			SHAPE_SAW:      wave_val = $signed({1'b0, p}) - 17'sd32768;
			default:        wave_val = p[15] ? -$signed(mag) : $signed(mag);
		endcase
	end

	assign prod_full = wave_s1 * $signed({1'b0, volume_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			phase_q  <= '0;
			inc_q    <= '0;
			wave_q   <= SHAPE_SINE;
			volume_q <= VOL_DEFAULT;
			wave_s1  <= '0;
			prod_s2  <= '0;
			link_q   <= '0;
			sum_q    <= '0;
		end else begin
			wave_s1 <= wave_val;
			prod_s2 <= PROD_W'(prod_full);
			link_q  <= link_in;
			sum_q   <= sum_in;
			if (link_in.valid) begin
				unique case (link_in.op)
					OP_TICK: begin
						if (active_q) begin
							phase_q <= phase_q + inc_q;
							sum_q   <= sum_in + SUM_W'(prod_s2);
						end
					end
					OP_ON: begin
						if (hit) begin
							active_q <= 1'b1;
							phase_q  <= '0;
							inc_q    <= link_in.inc;
							wave_q   <= link_in.wave;
							volume_q <= link_in.volume;
						end
					end
					OP_OFF: begin
						if (hit) begin
							active_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign link_out = link_q;
	assign sum_out  = sum_q;

endmodule

@@ design/mvo_clip.sv @@
// Output stage: scales the chain sum by the amplitude, clips to +-amplitude,
// truncates toward zero and holds the sample for the result channel.
// Depends on mvo_pkg and mvo_stream_if.
module mvo_clip
	import mvo_pkg::*;
#(
	parameter int SUM_W = 27
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    sum_valid,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [14:0]             amplitude,
	output logic                    busy,
	mvo_stream_if.source            result
);

	localparam int MIX_W = SUM_W + 16;

	logic signed [MIX_W-1:0] mix_s1;
	logic                    mix_valid_q;
	logic                    out_valid_q;
	logic signed [15:0]      sample_q;

	logic signed [MIX_W-1:0] limit;
	logic signed [MIX_W-1:0] adjusted;
	logic signed [15:0]      clipped;
	logic                    load_out;
	result_t                 res;

	always_comb begin
		limit    = MIX_W'($signed({1'b0, amplitude, 22'd0}));
		adjusted = mix_s1 + (mix_s1[MIX_W-1] ? MIX_W'(22'h3FFFFF) : MIX_W'(0));
		if (mix_s1 > limit) begin
			clipped = $signed({1'b0, amplitude});
		end else if (mix_s1 < -limit) begin
			clipped = -$signed({1'b0, amplitude});
		end else begin
			clipped = $signed(adjusted[37:22]);
		end
	end

	assign load_out = mix_valid_q && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				mix_valid_q <= 1'b0;
			end
			if (sum_valid) begin
				mix_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid) begin
			mix_s1 <= sum * $signed({1'b0, amplitude});
		end
		if (load_out) begin
			sample_q <= clipped;
		end
	end

	assign res.sample  = sample_q;
	assign result.data = res;
	assign result.valid = out_valid_q;
	assign busy = mix_valid_q;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench for multi_voice_oscillator_mixer: directed and random requests checked against
// an in-bench model of the voices, the wave shapes and the clipped mix.
// Depends on mvo_pkg, mvo_stream_if and the multi_voice_oscillator_mixer RTL.
module tb;
	import mvo_pkg::*;

	localparam int VOICES = 5;
	localparam int SETTLE = VOICES + 15;

	int sine_quarter [33] = '{
		0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
		12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
		23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
		30273, 30852, 31356, 31785, 32138, 32413, 32609, 32729,
		32768
	};
	int note_base_q12 [12] = '{
		1802240, 1909407, 2022946, 2143237, 2270680, 2405702,
		2548752, 2700309, 2860878, 3030994, 3211227, 3402176
	};
	wave_t inst_wave [6] = '{SHAPE_SINE, SHAPE_SINE, SHAPE_SQUARE, SHAPE_TRIANGLE, SHAPE_SAW,
		SHAPE_SQUARE};
	logic [7:0] inst_level [6] = '{8'd100, 8'd120, 8'd100, 8'd110, 8'd90, 8'd70};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [14:0] cfg_wdata;

	mvo_stream_if #(.data_t(item_t)) item_if ();
	mvo_stream_if #(.data_t(result_t)) result_if ();

	multi_voice_oscillator_mixer #(.VOICE_COUNT(VOICES)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.item(item_if),
		.result(result_if)
	);

	logic [14:0] amp_model;
	logic osc_on [VOICES];
	logic [PHASE_BITS-1:0] osc_phase [VOICES];
	logic [PHASE_BITS-1:0] osc_step [VOICES];
	wave_t osc_wave [VOICES];
	logic [7:0] osc_level [VOICES];
	logic signed [15:0] expected_samples [$];
	int fail_count = 0;
	bit tx_idle = 1'b0;
	bit rx_idle = 1'b0;
	int rx_hold = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [PHASE_BITS-1:0] note_step(logic [6:0] note);
		longint unsigned num;
		longint unsigned den;
		int m;
		m = note + 2;
		num = longint'(note_base_q12[m % 12]) << (PHASE_BITS + m / 12);
		den = longint'(RATE_HZ) << 15;
		return PHASE_BITS'((num + den / 2) / den);
	endfunction

	function automatic int sine_level(logic [15:0] p);
		int r;
		int idx;
		int frac;
		int v;
		r = int'(p[13:0]);
		if (p[14]) begin
			r = 16384 - r;
		end
		idx = r >> 9;
		frac = r & 511;
		if (idx >= 32) begin
			v = sine_quarter[32];
		end else begin
			v = sine_quarter[idx] + (((sine_quarter[idx + 1] - sine_quarter[idx]) * frac) >> 9);
		end
		return p[15] ? -v : v;
	endfunction

	function automatic int wave_level(wave_t w, logic [PHASE_BITS-1:0] ph);
		int p;
		p = int'(ph[PHASE_BITS-1 -: 16]);
		case (w)
			SHAPE_SQUARE: return (p < 32768) ? 32768 : -32768;
			SHAPE_TRIANGLE: begin
				if (p < 16384) return 2 * p;
				if (p < 49152) return 65536 - 2 * p;
				return 2 * p - 131072;
			end
			SHAPE_SAW: return p - 32768;
			default: return sine_level(p[15:0]);
		endcase
	endfunction

	task automatic mix_request(input item_t req);
		longint total;
		longint limit;
		longint level;
		int sel;
		total = 0;
		limit = longint'(amp_model) <<< 22;
		if (req.func == FUNC_TICK) begin
			for (int v = 0; v < VOICES; v++) begin
				if (osc_on[v]) begin
					total += longint'(wave_level(osc_wave[v], osc_phase[v])) *
						longint'(osc_level[v]) * longint'(amp_model);
					osc_phase[v] += osc_step[v];
				end
			end
			if (total > limit) begin
				level = longint'(amp_model);
			end else if (total < -limit) begin
				level = -longint'(amp_model);
			end else begin
				level = total / (longint'(1) <<< 22);
			end
			expected_samples.push_back(level[15:0]);
		end else if (req.channel < VOICES) begin
			if (req.func == FUNC_NOTE_ON && req.note >= 1 && req.note <= NOTE_MAX) begin
				sel = (req.instrument >= 1 && req.instrument <= 5) ? int'(req.instrument) : 0;
				osc_on[req.channel] = 1'b1;
				osc_phase[req.channel] = '0;
				osc_step[req.channel] = note_step(req.note);
				osc_wave[req.channel] = inst_wave[sel];
				osc_level[req.channel] = inst_level[sel];
				if (req.effect[15:8] == FX_VOLUME) begin
					osc_level[req.channel] = req.effect[7:0];
				end
			end else if (req.func == FUNC_NOTE_OFF) begin
				osc_on[req.channel] = 1'b0;
			end
		end
	endtask

	function automatic item_t make_request(func_t f, int ch, int nt, int inst, int fx);
		item_t r;
		r.func = f;
		r.channel = 3'(ch);
		r.note = 7'(nt);
		r.instrument = 8'(inst);
		r.effect = 16'(fx);
		return r;
	endfunction

	function automatic item_t random_request();
		item_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.channel = 3'($urandom_range(0, VOICES - 1));
		r.note = 7'($urandom_range(1, NOTE_MAX));
		r.instrument = 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) :
			$urandom_range(0, 6));
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				r.effect = 16'($urandom());
				r.effect[15:8] = FX_VOLUME;
			end
			3: r.effect = 16'($urandom());
			default: r.effect = '0;
		endcase
		if (pick < 55) begin
			r.func = FUNC_TICK;
		end else if (pick < 78) begin
			r.func = FUNC_NOTE_ON;
		end else if (pick < 92) begin
			r.func = FUNC_NOTE_OFF;
		end else begin
			r.func = 2'($urandom_range(0, 3));
			r.channel = 3'($urandom_range(0, 7));
			r.note = 7'($urandom_range(0, 127));
		end
		return r;
	endfunction

	// Entered and left at a falling edge; valid stays high for a back-to-back request.
	task automatic send_request(input item_t req);
		int gap;
		gap = tx_idle ? $urandom_range(0, 18) : 0;
		if (gap > 0) begin
			item_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_if.data <= req;
		item_if.valid <= 1'b1;
		do @(posedge clk); while (!item_if.ready);
		mix_request(req);
		@(negedge clk);
	endtask

	task automatic drain_results();
		item_if.valid <= 1'b0;
		for (int n = 0; n < 5000 && expected_samples.size() != 0; n++) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_amplitude(input logic [14:0] level);
		drain_results();
		cfg_wdata <= level;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		amp_model = level;
	endtask

	task automatic test_silence();
		repeat (2) send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_note_on_cases();
		send_request(make_request(FUNC_NOTE_ON, 4, NOTE_MAX, 2, 16'h0C80));
		send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
		send_request(make_request(FUNC_NOTE_ON, 0, 1, 1, 16'h0000));
		send_request(make_request(FUNC_NOTE_ON, 1, 34, 3, 16'h0CFF));
		send_request(make_request(FUNC_NOTE_ON, 2, 60, 4, 16'h0B55));
		send_request(make_request(FUNC_NOTE_ON, 3, 12, 5, 16'hFFFF));
		repeat (2) send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
		send_request(make_request(FUNC_NOTE_ON, 3, 40, 0, 16'h0C00));
		send_request(make_request(FUNC_NOTE_ON, 2, NOTE_MAX, 255, 16'h0000));
		send_request(make_request(FUNC_TICK, 7, 127, 255, 16'hFFFF));
	endtask

	task automatic test_ignored_requests();
		send_request(make_request(FUNC_NOTE_ON, VOICES, 34, 1, 16'h0000));
		send_request(make_request(FUNC_NOTE_ON, 7, 34, 1, 16'h0000));
		send_request(make_request(FUNC_NOTE_ON, 0, 0, 2, 16'h0000));
		send_request(make_request(FUNC_NOTE_ON, 0, NOTE_MAX + 1, 2, 16'h0000));
		send_request(make_request(FUNC_NOTE_ON, 0, 127, 2, 16'h0C10));
		send_request(make_request(FUNC_UNUSED, 1, 34, 1, 16'h0C10));
		send_request(make_request(FUNC_NOTE_OFF, 7, 0, 0, 16'h0000));
		send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_note_off();
		send_request(make_request(FUNC_NOTE_OFF, 4, 0, 0, 16'h0000));
		send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
		for (int ch = 0; ch < 4; ch++) begin
			send_request(make_request(FUNC_NOTE_OFF, ch, 0, 0, 16'h0000));
		end
		send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
	endtask

	// Hold the result side for a long stretch while ticks keep coming.
	task automatic test_output_backpressure();
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_request(make_request(FUNC_NOTE_ON, 1, 50, 4, 16'h0000));
		rx_hold = 300;
		repeat (12) send_request(make_request(FUNC_TICK, 0, 0, 0, 0));
	endtask

	task automatic test_random_settings();
		logic [14:0] level;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: level = 15'h7FFF;
				1: level = 15'd0;
				2: level = 15'd1;
				3: level = AMP_RESET;
				default: level = 15'($urandom_range(0, 32767));
			endcase
			set_amplitude(level);
			tx_idle = ph[0];
			rx_idle = ph[1];
			repeat (240) send_request(random_request());
		end
	endtask

	initial begin : sample_checker
		int gap;
		logic signed [15:0] want;
		result_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end else begin
				gap = rx_idle ? $urandom_range(0, 18) : 0;
			end
			if (gap > 0) begin
				result_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_if.ready <= 1'b1;
			do @(posedge clk); while (!result_if.valid);
			if (expected_samples.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("sample %0d with no request pending", result_if.data.sample);
				end
			end else begin
				want = expected_samples.pop_front();
				if (result_if.data.sample !== want) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("sample mismatch: expected %0d, got %0d", want,
							result_if.data.sample);
					end
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_if.valid = 1'b0;
		item_if.data = '0;
		amp_model = AMP_RESET;
		for (int v = 0; v < VOICES; v++) begin
			osc_on[v] = 1'b0;
			osc_phase[v] = '0;
			osc_step[v] = '0;
			osc_wave[v] = SHAPE_SINE;
			osc_level[v] = VOL_DEFAULT;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_silence();
		test_note_on_cases();
		test_ignored_requests();
		test_note_off();
		test_output_backpressure();
		test_random_settings();
		drain_results();
		fail_count += expected_samples.size();
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
